[hdl/ppr_pkg.sv]
// Package with constants and types shared by the per-peer replay window files.
package ppr_pkg;

    // Number of peer slots and the largest accepted age window.
    localparam int PEERS      = 8;
    localparam int WINDOW_MAX = 64;

    // Fixed field widths.
    localparam int PEER_W     = 3;
    localparam int SEQ_W      = 32;
    localparam int CFG_W      = 8;
    localparam int MASK_BITS  = 64;
    localparam int MASK_AW    = $clog2(MASK_BITS);

    // Derived widths.
    localparam int PEER_AW    = (PEERS > 1) ? $clog2(PEERS) : 1;
    localparam int WIN_W      = $clog2(WINDOW_MAX + 1);
    localparam int REC_W      = SEQ_W + MASK_BITS;

    // Sequencer states.
    typedef enum logic {
        PPR_IDLE,
        PPR_EXEC
    } ppr_state_t;

endpackage

[hdl/ppr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module ppr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/per_peer_replay_window_core.sv]
// Top level of the per-peer anti-replay window check.
//
// Each input transaction names a peer slot and a 32-bit sequence number and
// yields one result transaction whose fresh bit accepts (1) or rejects (0)
// the packet. In the cycle of acceptance the peer's record (highest sequence
// and 64-bit seen mask) is read from the record RAM, and in the next cycle
// the record is updated and written back while the result is loaded into
// the output register. No new transaction is taken until that check is done
// and the output register is free. Started flags live in flip-flops and are
// cleared by reset, so no clearing pass is needed. Slots at or beyond the
// number of peers are rejected without any state change. A window size of
// 0 or above 64 means 64; write it only while the block is idle.
module per_peer_replay_window_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [ppr_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ppr_pkg::PEER_W-1:0]  s_peer_index,
    input  logic [ppr_pkg::SEQ_W-1:0]   s_sequence_req,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_fresh
);

    import ppr_pkg::*;

    ppr_state_t              state_reg, state_next;
    logic [CFG_W-1:0]        window_reg;
    logic [PEERS-1:0]        started_reg;
    logic [PEER_AW-1:0]      addr_reg;
    logic                    in_range_reg;
    logic [SEQ_W-1:0]        seq_reg;
    logic                    m_valid_reg;
    logic                    fresh_reg;

    logic                    s_accept;
    logic [WIN_W-1:0]        eff_window;
    logic [REC_W-1:0]        rd_data;
    logic [SEQ_W-1:0]        rd_highest;
    logic [MASK_BITS-1:0]    rd_mask;
    logic [SEQ_W-1:0]        delta;
    logic [SEQ_W-1:0]        age;
    logic                    ram_we;
    logic [SEQ_W-1:0]        wr_highest;
    logic [MASK_BITS-1:0]    wr_mask;
    logic                    fresh_calc;
    logic                    start_slot;

    assign s_accept = s_valid && s_ready;

    // Record RAM: highest sequence in the upper bits, seen mask in the lower.
    ppr_ram #(
        .WIDTH (REC_W),
        .DEPTH (PEERS),
        .AW    (PEER_AW)
    ) u_rec_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (addr_reg),
        .wr_data ({wr_highest, wr_mask}),
        .rd_en   (s_accept),
        .rd_addr (PEER_AW'(s_peer_index)),
        .rd_data (rd_data)
    );

    assign rd_highest = rd_data[REC_W-1:MASK_BITS];
    assign rd_mask    = rd_data[MASK_BITS-1:0];

    // Effective window: zero or anything above the maximum means the maximum.
    always_comb begin
        if (window_reg == '0 || 32'(window_reg) > WINDOW_MAX) begin
            eff_window = WIN_W'(WINDOW_MAX);
        end else begin
            eff_window = WIN_W'(window_reg);
        end
    end

    assign delta = seq_reg - rd_highest;
    assign age   = rd_highest - seq_reg;

    // Window check and record update for the transaction in flight.
    always_comb begin
        ram_we     = 1'b0;
        wr_highest = rd_highest;
        wr_mask    = rd_mask;
        fresh_calc = 1'b0;
        start_slot = 1'b0;
        if (in_range_reg) begin
            if (!started_reg[addr_reg]) begin
                start_slot = 1'b1;
                ram_we     = 1'b1;
                fresh_calc = 1'b1;
                wr_highest = seq_reg;
                wr_mask    = MASK_BITS'(1);
            end else if (seq_reg > rd_highest) begin
                ram_we     = 1'b1;
                fresh_calc = 1'b1;
                wr_highest = seq_reg;
                if (delta >= SEQ_W'(MASK_BITS)) begin
                    wr_mask = MASK_BITS'(1);
                end else begin
                    wr_mask = (rd_mask << delta[MASK_AW-1:0]) | MASK_BITS'(1);
                end
            end else if (age >= SEQ_W'(eff_window) || age >= SEQ_W'(MASK_BITS)) begin
                fresh_calc = 1'b0;
            end else if (rd_mask[age[MASK_AW-1:0]]) begin
                fresh_calc = 1'b0;
            end else begin
                ram_we     = 1'b1;
                fresh_calc = 1'b1;
                wr_mask    = rd_mask | (MASK_BITS'(1) << age[MASK_AW-1:0]);
            end
        end
        if (state_reg != PPR_EXEC) begin
            ram_we     = 1'b0;
            start_slot = 1'b0;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            PPR_IDLE: begin
                if (s_accept) begin
                    state_next = PPR_EXEC;
                end
            end
            PPR_EXEC: begin
                state_next = PPR_IDLE;
            end
            default: begin
                state_next = PPR_IDLE;
            end
        endcase
    end

    // Outputs: accept only when idle and the output register frees up.
    always_comb begin
        case (state_reg)
            PPR_IDLE: s_ready = !m_valid_reg || m_ready;
            default:  s_ready = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= PPR_IDLE;
            window_reg  <= '0;
            started_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
            if (start_slot) begin
                started_reg[addr_reg] <= 1'b1;
            end
            if (state_reg == PPR_EXEC) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            addr_reg     <= PEER_AW'(s_peer_index);
            in_range_reg <= 32'(s_peer_index) < PEERS;
            seq_reg      <= s_sequence_req;
        end
        if (state_reg == PPR_EXEC) begin
            fresh_reg <= fresh_calc;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_fresh = fresh_reg;

    // An accepted transaction is always checked in the following cycle.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == PPR_EXEC)
        else $error("accepted transaction did not reach the check cycle");

    // The check cycle always loads a result into the output register.
    a_exec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == PPR_EXEC |=> m_valid_reg && state_reg == PPR_IDLE)
        else $error("check cycle did not produce a result");

    // A slot out of range never changes the record RAM.
    a_range_nowrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == PPR_EXEC && !in_range_reg) |-> !ram_we)
        else $error("record written for a slot out of range");

    // The first packet of a slot is always accepted as fresh.
    a_first_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        start_slot |=> m_fresh)
        else $error("first packet of a slot was rejected");

endmodule

[tb/tb_top.sv]
// Testbench for the per-peer anti-replay window: predicts each fresh verdict and checks it.
module tb_top;
    import ppr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    // One predicted verdict, kept with the packet that caused it.
    typedef struct {
        logic [PEER_W-1:0] peer;
        logic [SEQ_W-1:0]  seq;
        logic              fresh;
    } verdict_t;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               cfg_wr_en      = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data    = '0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [PEER_W-1:0]  s_peer_index   = '0;
    logic [SEQ_W-1:0]   s_sequence_req = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic               m_fresh;

    // Predictor state: window register copy and the per-slot records.
    logic [CFG_W-1:0]     win_setting = '0;
    logic                 slot_started [PEERS] = '{default: 1'b0};
    logic [SEQ_W-1:0]     slot_highest [PEERS];
    logic [MASK_BITS-1:0] slot_seen    [PEERS];

    verdict_t pending_verdicts[$];
    int       fail_count   = 0;
    bit       idle_on      = 1'b1;
    int       rx_hold      = 0;
    int       quiet_cycles = 0;

    always #2 aclk = ~aclk;

    per_peer_replay_window_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_peer_index   (s_peer_index),
        .s_sequence_req (s_sequence_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fresh        (m_fresh)
    );

    // Verdict for one packet; updates the slot record the same way the block does.
    function automatic logic predict_fresh(input logic [PEER_W-1:0] peer,
                                           input logic [SEQ_W-1:0] seq);
        int unsigned     slot;
        int unsigned     win;
        logic [SEQ_W-1:0] delta;
        logic [SEQ_W-1:0] age;
        slot = 32'(peer);
        if (slot >= PEERS) begin
            return 1'b0;
        end
        win = 32'(win_setting);
        if (win == 0 || win > WINDOW_MAX) begin
            win = WINDOW_MAX;
        end
        // The first packet of a slot starts its record.
        if (!slot_started[slot]) begin
            slot_started[slot] = 1'b1;
            slot_highest[slot] = seq;
            slot_seen[slot]    = 64'd1;
            return 1'b1;
        end
        // A newer sequence slides the seen mask.
        if (seq > slot_highest[slot]) begin
            delta = seq - slot_highest[slot];
            if (delta >= MASK_BITS) begin
                slot_seen[slot] = '0;
            end else begin
                slot_seen[slot] = slot_seen[slot] << delta;
            end
            slot_seen[slot][0] = 1'b1;
            slot_highest[slot] = seq;
            return 1'b1;
        end
        // An older or equal sequence must be inside the window and unseen.
        age = slot_highest[slot] - seq;
        if (age >= win || age >= MASK_BITS) begin
            return 1'b0;
        end
        if (slot_seen[slot][age[MASK_AW-1:0]]) begin
            return 1'b0;
        end
        slot_seen[slot][age[MASK_AW-1:0]] = 1'b1;
        return 1'b1;
    endfunction

    // Idle length: mostly none, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(8, 40);
    endfunction

    // Sequence for a random packet, mostly close to the slot's highest one.
    function automatic logic [SEQ_W-1:0] next_seq(input logic [PEER_W-1:0] peer);
        int r;
        logic [SEQ_W-1:0] top;
        r   = $urandom_range(0, 99);
        top = slot_highest[peer];
        if (!slot_started[peer] || r < 5) begin
            return $urandom();
        end
        if (r < 40) begin
            return top + $urandom_range(1, 4);
        end
        if (r < 50) begin
            return top + $urandom_range(5, 200);
        end
        if (r < 95) begin
            return top - $urandom_range(0, 70);
        end
        return top - $urandom_range(71, 100000);
    endfunction

    task automatic report_bad(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("mismatch: %s", msg);
        end
    endtask

    // Sends one packet transaction and records its predicted verdict on acceptance.
    task automatic send_packet(input logic [PEER_W-1:0] peer, input logic [SEQ_W-1:0] seq);
        int       gap;
        verdict_t v;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_peer_index   <= peer;
        s_sequence_req <= seq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        v.peer  = peer;
        v.seq   = seq;
        v.fresh = predict_fresh(peer, seq);
        pending_verdicts.push_back(v);
    endtask

    // Stops sending and waits until every predicted verdict has been checked.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_window(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        win_setting = value;
    endtask

    // Result side: check each verdict transaction, then pick the next ready value.
    always @(posedge aclk) begin : result_side
        verdict_t exp;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_bad($sformatf("unexpected result fresh=%b", m_fresh));
            end else begin
                exp = pending_verdicts.pop_front();
                if (m_fresh !== exp.fresh) begin
                    report_bad($sformatf("peer=%0d seq=%h expected fresh=%b got %b",
                                         exp.peer, exp.seq, exp.fresh, m_fresh));
                end
            end
        end
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else begin
            m_ready <= 1'b1;
            rx_hold = pick_gap();
        end
    end

    // Watchdog: ends the run after too many cycles with no transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // First packets, replays, the wrap case and large jumps at the reset window.
    task automatic test_first_packets();
        idle_on = 1'b1;
        send_packet(3'd0, 32'd0);
        send_packet(3'd0, 32'd0);
        send_packet(3'd1, 32'hFFFF_FFFF);
        send_packet(3'd1, 32'd5);
        send_packet(3'd1, 32'hFFFF_FFFF);
        send_packet(3'd2, 32'd100);
        send_packet(3'd2, 32'd163);
        send_packet(3'd2, 32'd100);
        send_packet(3'd2, 32'd101);
        send_packet(3'd2, 32'd99);
        send_packet(3'd3, 32'h8000_0000);
        send_packet(3'd3, 32'h7FFF_FFFF);
        send_packet(3'd0, 32'd1);
        send_packet(3'd0, 32'd0);
        send_packet(3'd0, 32'd65);
        send_packet(3'd0, 32'd2);
        send_packet(3'd0, 32'd1);
        send_packet(3'd0, 32'd65);
        send_packet(3'd4, 32'd10);
    endtask

    // Smallest window, window values that mean the maximum, and the edges of 64.
    task automatic test_window_extremes();
        set_window(8'd1);
        send_packet(3'd4, 32'd9);
        send_packet(3'd4, 32'd11);
        send_packet(3'd4, 32'd10);
        set_window(8'd255);
        send_packet(3'd4, 32'd9);
        set_window(8'd64);
        send_packet(3'd3, 32'h7FFF_FFC1);
        set_window(8'd65);
        send_packet(3'd3, 32'h7FFF_FFC0);
        send_packet(3'd3, 32'h7FFF_FFC2);
    endtask

    task automatic test_random_traffic(input logic [CFG_W-1:0] win, input int count,
                                       input bit idles);
        logic [PEER_W-1:0] peer;
        set_window(win);
        idle_on = idles;
        repeat (count) begin
            peer = PEER_W'($urandom_range(0, PEERS - 1));
            send_packet(peer, next_seq(peer));
        end
    endtask

    // The sender stops in the middle of the stream until all verdicts are in.
    task automatic test_pause_midstream();
        logic [PEER_W-1:0] peer;
        set_window(CFG_W'($urandom_range(0, 255)));
        idle_on = 1'b1;
        repeat (100) begin
            peer = PEER_W'($urandom_range(0, PEERS - 1));
            send_packet(peer, next_seq(peer));
        end
        wait_idle();
        repeat (100) begin
            peer = PEER_W'($urandom_range(0, PEERS - 1));
            send_packet(peer, next_seq(peer));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_packets();
        test_window_extremes();
        test_random_traffic(8'd0, 180, 1'b1);
        test_random_traffic(8'd1, 180, 1'b1);
        test_random_traffic(8'd255, 180, 1'b0);
        test_random_traffic(8'd64, 180, 1'b1);
        test_random_traffic(8'd65, 180, 1'b1);
        test_random_traffic(8'd8, 150, 1'b1);
        test_pause_midstream();

        idle_on = 1'b1;
        wait_idle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_verdicts.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
